// ===== rtl/sfm_pkg.sv =====
package sfm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam longint MAX_TARGET = 65536;

	localparam int PAT_IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = PAT_IDX_W + 1;
	localparam int CNT_W = $clog2(MAX_TARGET) + 1;
	localparam int OFFSET_W = 16;
	localparam int BYTE_W = 8;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TARGET = 1'b1;

	typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_vec_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic kind;
		logic [BYTE_W-1:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [OFFSET_W-1:0] match_offset;
	} out_item_t;

endpackage

// ===== rtl/sfm_window_cmp.sv =====
module sfm_window_cmp
	import sfm_pkg::*;
(
	input byte_vec_t window,
	input byte_vec_t pattern,
	input len_t eff_len,
	output logic match
);

	byte_vec_t rev;
	byte_vec_t aligned;
	logic [PAT_IDX_W-1:0] shamt;
	logic [LEN_W-1:0] shamt_full;
	logic [MAX_PATTERN-1:0] eq;

	// Reverse so oldest sits low, then drop the bytes older than the pattern span.
	always_comb begin
		for (int m = 0; m < MAX_PATTERN; m++) begin
			rev[m] = window[MAX_PATTERN-1-m];
		end
	end

	assign shamt_full = LEN_W'(MAX_PATTERN) - eff_len;
	assign shamt = shamt_full[PAT_IDX_W-1:0];
	assign aligned = byte_vec_t'(rev >> {shamt, 3'b000});

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			eq[k] = (aligned[k] == pattern[k]) || (LEN_W'(k) >= eff_len);
		end
	end

	assign match = &eq;

endmodule

// ===== rtl/substring_first_match_unit.sv =====
// Channel | Signals                        | Payload
// --------+--------------------------------+----------------------------------
// in      | in_valid, in_ready, in_data    | kind, data_byte, last_byte
// out     | out_valid, out_ready, out_data | found, match_offset
// cfg     | cfg_we, cfg_wdata              | pattern_length (6 bits)
//
// One request per cycle sustained while results are taken. A request waits in
// the input stage until the result slot is free; then its result is registered.
// The limiting path is the window shift, aligning barrel shifter and 32 byte
// comparators feeding the result register.
// arst_n clears the window, byte count, match flag, fill index and valid bits;
// the pattern store holds no reset value.
// A stalled result blocks only the input stage; a new request still enters
// while the input stage is empty or draining.
module substring_first_match_unit
	import sfm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [LEN_W-1:0] cfg_wdata
);

	// Input stage
	logic s1_valid_q;
	in_item_t item_s1;
	logic s1_go;

	// Search state
	len_t pat_len_q;
	byte_vec_t pattern_q;
	logic [PAT_IDX_W-1:0] fill_q;
	byte_vec_t window_q;
	logic [CNT_W-1:0] seen_q;
	logic matched_q;

	// Result stage
	logic out_valid_q;
	out_item_t out_q;

	// Working signals
	len_t eff_len;
	logic is_target;
	logic active;
	byte_vec_t window_shift;
	logic [CNT_W-1:0] seen_inc;
	logic win_match;
	logic hit;
	logic miss_end;
	logic [CNT_W-1:0] offset_full;
	out_item_t res;

	// Advance the input stage only when the result slot is free.
	assign s1_go = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_go;

	// Clamp the length register to 1..MAX_PATTERN.
	always_comb begin
		priority if (pat_len_q == '0) begin
			eff_len = len_t'(1);
		end else if (pat_len_q > len_t'(MAX_PATTERN)) begin
			eff_len = len_t'(MAX_PATTERN);
		end else begin
			eff_len = pat_len_q;
		end
	end

	assign is_target = (item_s1.kind == KIND_TARGET);
	// Compare only while no match yet and the byte count is below saturation.
	assign active = is_target && !matched_q && (seen_q < CNT_W'(MAX_TARGET));
	assign window_shift = {window_q[MAX_PATTERN-2:0], item_s1.data_byte};
	assign seen_inc = seen_q + CNT_W'(1);

	sfm_window_cmp u_cmp (
		.window(window_shift),
		.pattern(pattern_q),
		.eff_len(eff_len),
		.match(win_match)
	);

	assign hit = active && (seen_inc >= CNT_W'(eff_len)) && win_match;
	// Report not-found on the last byte unless a match was ever reported.
	assign miss_end = is_target && item_s1.last_byte && !matched_q && !hit;
	assign offset_full = seen_inc - CNT_W'(eff_len);

	always_comb begin
		res.found = hit;
		res.match_offset = hit ? offset_full[OFFSET_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= len_t'(1);
		end else if (cfg_we) begin
			pat_len_q <= cfg_wdata;
		end
	end

	// Pattern store: written one byte at a time, no reset.
	always_ff @(posedge clk) begin
		if (s1_go && !is_target) begin
			pattern_q[fill_q] <= item_s1.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			window_q <= '0;
			seen_q <= '0;
			matched_q <= 1'b0;
		end else if (s1_go) begin
			if (!is_target) begin
				fill_q <= fill_q + PAT_IDX_W'(1);
			end else if (item_s1.last_byte) begin
				// End of target: drop the search state.
				fill_q <= '0;
				window_q <= '0;
				seen_q <= '0;
				matched_q <= 1'b0;
			end else if (active) begin
				window_q <= window_shift;
				seen_q <= seen_inc;
				if (hit) begin
					matched_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= hit || miss_end;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== tb/search_scoreboard_pkg.sv =====
package search_scoreboard_pkg;
	import sfm_pkg::*;

	class search_scoreboard;
		logic [LEN_W-1:0] length_reg;
		logic [BYTE_W-1:0] pattern_mem [MAX_PATTERN];
		logic [PAT_IDX_W-1:0] fill_ptr;
		logic [BYTE_W-1:0] window_mem [MAX_PATTERN];
		logic [CNT_W-1:0] bytes_seen;
		bit matched;
		out_item_t due_results [$];
		int mismatches;

		function new();
			length_reg = LEN_W'(1);
			foreach (pattern_mem[i]) pattern_mem[i] = '0;
			clear_search();
			mismatches = 0;
		endfunction

		function void clear_search();
			foreach (window_mem[i]) window_mem[i] = '0;
			bytes_seen = '0;
			matched = 1'b0;
			fill_ptr = '0;
		endfunction

		function int active_length();
			if (length_reg == 0) return 1;
			if (length_reg > MAX_PATTERN) return MAX_PATTERN;
			return int'(length_reg);
		endfunction

		function logic [BYTE_W-1:0] pattern_byte(int pos);
			return pattern_mem[pos];
		endfunction

		function void set_length(logic [LEN_W-1:0] value);
			length_reg = value;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Advance the search state by one accepted request and queue any result.
		function void note_request(in_item_t req);
			int len;
			int i;
			bit hit;
			out_item_t res;
			if (req.kind == KIND_PATTERN) begin
				pattern_mem[fill_ptr] = req.data_byte;
				fill_ptr = fill_ptr + 1'b1;
				return;
			end
			if (!matched && bytes_seen < MAX_TARGET) begin
				len = active_length();
				for (i = MAX_PATTERN - 1; i > 0; i--) window_mem[i] = window_mem[i-1];
				window_mem[0] = req.data_byte;
				bytes_seen = bytes_seen + 1'b1;
				if (bytes_seen >= len) begin
					hit = 1'b1;
					for (i = 0; i < len; i++)
						if (pattern_mem[i] != window_mem[len-1-i]) hit = 1'b0;
					if (hit) begin
						matched = 1'b1;
						res.found = 1'b1;
						res.match_offset = OFFSET_W'(int'(bytes_seen) - len);
						due_results.push_back(res);
					end
				end
			end
			if (req.last_byte) begin
				if (!matched) begin
					res.found = 1'b0;
					res.match_offset = '0;
					due_results.push_back(res);
				end
				clear_search();
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual found=%0b offset=%0d",
					$time, got.found, got.match_offset);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.found !== want.found) begin
				$display("%0t: found: expected %0b, actual %0b", $time, want.found, got.found);
				mismatches++;
			end
			if (got.match_offset !== want.match_offset) begin
				$display("%0t: match_offset: expected %0d, actual %0d",
					$time, want.match_offset, got.match_offset);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfm_pkg::*;
	import search_scoreboard_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	search_scoreboard sb;

	// Pacing knobs set by the phase sequencer for the sender and the receiver, and the sent-item count.
	bit tx_fast;
	bit rx_fast;
	int rx_hold_cycles;
	int items_sent;

	substring_first_match_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case a result never shows up or the input stalls forever.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Observe every handshake at the edge where it happens. Requests are noted
	// before results are checked, so a same-edge pair stays in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_request(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if (cfg_we) sb.set_length(cfg_wdata);
		end
	end

	// Receiver: draw a stall before each result, or take a long hold-off when
	// the sequencer asks for one so the block backs up into its input.
	initial begin
		int gap;
		int hold;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				hold = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else begin
				gap = rx_fast ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Offer one request after a random gap and hold it until accepted. Valid
	// stays high on return so back-to-back requests need no extra edge.
	task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value,
			input logic last);
		int gap;
		in_item_t req;
		gap = tx_fast ? 0 : $urandom_range(0, 14);
		req.kind = kind;
		req.data_byte = value;
		req.last_byte = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
	endtask

	// Drop valid and wait until every queued result has been taken. Pattern
	// loads give no result, so also let the pipeline empty before returning.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called with the block idle. The trailing edge lets the scoreboard
	// pick up the new length before the caller reads it back.
	task automatic write_length(input logic [LEN_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One target of random content. Mostly plant a copy of the pattern, often
	// draw bytes from the pattern's own alphabet to provoke near misses, and
	// now and then slip in a pattern load mid-search.
	task automatic run_search(input int tgt_len);
		int plen;
		int pos;
		int i;
		bit plant;
		bit narrow;
		logic [BYTE_W-1:0] b;
		plen = sb.active_length();
		plant = ($urandom_range(0, 2) != 0) && (tgt_len >= plen);
		pos = plant ? $urandom_range(0, tgt_len - plen) : -1;
		narrow = 1'($urandom_range(0, 1));
		for (i = 0; i < tgt_len; i++) begin
			if (plant && i >= pos && i < pos + plen) b = sb.pattern_byte(i - pos);
			else if (narrow) b = sb.pattern_byte($urandom_range(0, plen - 1));
			else b = BYTE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 49) == 0)
				send_item(KIND_PATTERN, BYTE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			send_item(KIND_TARGET, b, i == tgt_len - 1);
		end
	endtask

	initial begin
		int k;
		int n;
		int r;
		int plen;
		logic [LEN_W-1:0] len_pick;

		sb = new();
		tx_fast = 1'b0;
		rx_fast = 1'b0;
		rx_hold_cycles = 0;
		items_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every pattern entry once so no comparison ever reads an
		// unwritten slot; the fill pointer wraps back to zero afterwards.
		send_item(KIND_PATTERN, 8'hA5, 1'b0);
		for (k = 1; k < MAX_PATTERN; k++)
			send_item(KIND_PATTERN, BYTE_W'($urandom_range(0, 255)), 1'b0);

		// Reset length of one: match on the final byte.
		send_item(KIND_TARGET, 8'h00, 1'b0);
		send_item(KIND_TARGET, 8'hFF, 1'b0);
		send_item(KIND_TARGET, 8'hA5, 1'b1);
		// Early match, then bytes ignored and no second result at the end.
		send_item(KIND_TARGET, 8'hA5, 1'b0);
		send_item(KIND_TARGET, 8'hA5, 1'b0);
		send_item(KIND_TARGET, 8'h00, 1'b1);
		// Single-byte target with no match.
		send_item(KIND_TARGET, 8'h11, 1'b1);
		// A last mark on a pattern load is ignored.
		send_item(KIND_PATTERN, 8'hFF, 1'b1);
		send_item(KIND_TARGET, 8'hFF, 1'b1);
		wait_drain();

		// Length zero behaves as one.
		write_length(6'd0);
		send_item(KIND_TARGET, 8'hFF, 1'b1);
		send_item(KIND_TARGET, 8'h00, 1'b1);
		wait_drain();

		// Oversized length clamps to the store size; a short target can't match.
		write_length(6'd63);
		send_item(KIND_TARGET, 8'h01, 1'b0);
		send_item(KIND_TARGET, 8'h02, 1'b1);
		wait_drain();

		// Reload the pattern in the middle of a search.
		write_length(6'd2);
		send_item(KIND_TARGET, 8'h01, 1'b0);
		send_item(KIND_PATTERN, 8'h10, 1'b0);
		send_item(KIND_PATTERN, 8'h20, 1'b0);
		send_item(KIND_TARGET, 8'h10, 1'b0);
		send_item(KIND_TARGET, 8'h20, 1'b1);
		wait_drain();

		// Back-pressure: hold the receiver off while a stream of one-byte
		// targets keeps coming, so the result path fills and stalls input.
		write_length(6'd1);
		tx_fast = 1'b1;
		rx_hold_cycles = 300;
		for (k = 0; k < 40; k++)
			send_item(KIND_TARGET, BYTE_W'($urandom_range(0, 255)), 1'b1);
		wait_drain();

		// Random phases: new length and pacing per phase, optional pattern
		// reload, then a handful of searches sized around the pattern.
		while (items_sent < 1900) begin
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				n = $urandom_range(1, MAX_PATTERN);
				for (k = 0; k < n; k++)
					send_item(KIND_PATTERN, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				wait_drain();
			end
			r = $urandom_range(0, 19);
			case (r)
				0: len_pick = 6'd0;
				1: len_pick = $urandom_range(0, 1) ? 6'd63 : 6'($urandom_range(33, 62));
				2: len_pick = 6'd32;
				3: len_pick = 6'd1;
				4, 5, 6, 7: len_pick = 6'($urandom_range(9, 32));
				default: len_pick = 6'($urandom_range(1, 8));
			endcase
			write_length(len_pick);
			plen = sb.active_length();
			n = $urandom_range(2, 6);
			for (k = 0; k < n; k++) begin
				// Mostly long enough to hold the pattern, sometimes shorter.
				if ($urandom_range(0, 5) == 0) run_search($urandom_range(1, plen));
				else run_search($urandom_range(plen, plen + 8));
			end
			wait_drain();
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
